>>> rtl/core/first_fit_block_allocator_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed: next-cycle rule");

`endif

>>> rtl/core/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int OFF_W       = 12;
   localparam int REQ_W       = 13;
   localparam int REQ_ROUND_W = REQ_W + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [REQ_W-1:0] request_size;
      logic [OFF_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [OFF_W-1:0] payload_offset;
      logic             ok;
   } rsp_type;

   // sub: a - b (else a + b); hdr: also subtract / add the header size
   typedef struct packed {
      logic sub;
      logic hdr;
   } alu_op_type;

   typedef struct packed {
      logic neg;
      logic ge_zone;
      logic gt_zone;
   } alu_flags_type;

endpackage

>>> rtl/core/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ffba_alu.sv
// Shared add/subtract unit with header offset and zone-limit flags.
module ffba_alu #(
   parameter int W            = 15,
   parameter int HEADER_BYTES = 16,
   parameter int ZONE_BYTES   = 4096
) (
   input  logic [W-1:0]            opa,
   input  logic [W-1:0]            opb,
   input  ffba_pkg::alu_op_type    op,
   output logic [W-1:0]            res,
   output ffba_pkg::alu_flags_type flags
);
   import ffba_pkg::*;

   localparam logic [W:0] HDR_X  = (W+1)'(HEADER_BYTES);
   localparam logic [W:0] ZONE_X = (W+1)'(ZONE_BYTES);

   logic [W:0] a_x;
   logic [W:0] b_x;
   logic [W:0] h_x;
   logic [W:0] sum_x;

   assign a_x   = {1'b0, opa};
   assign b_x   = {1'b0, opb};
   assign h_x   = op.hdr ? HDR_X : '0;
   assign sum_x = op.sub ? (a_x - b_x - h_x) : (a_x + b_x + h_x);

   assign res           = sum_x[W-1:0];
   assign flags.neg     = op.sub & sum_x[W];
   assign flags.ge_zone = !flags.neg && (sum_x >= ZONE_X);
   assign flags.gt_zone = !flags.neg && (sum_x > ZONE_X);

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// First-fit block allocator over one zone kept as a chain of boundary-tag headers.
//
//   channel | direction | payload                                   | handshake
//   req_    | in        | opcode, request_size, block_offset        | req_valid / req_ready
//   rsp_    | out       | payload_offset, ok                        | rsp_valid / rsp_ready
//
// Steps: allocate walks the header chain with one tag RAM read and one check per header,
// then splits the block, updates the tags and posts the result. Free reads up to four
// tags and rewrites up to three of them before it posts the result.
// The tag RAM read and the shared adder set the per-step cost.
// Reset: one cycle after reset writes the initial free block into tag entry 0.
// Stalls: a held result beat waits in the output register; the next request is taken
// meanwhile and parks in the respond step until the held beat drains.
module first_fit_block_allocator #(
   parameter int ZONE_BYTES   = 4096,
   parameter int HEADER_BYTES = 16,
   parameter int ALIGN_BYTES  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffba_pkg::rsp_type rsp_data
);
   import ffba_pkg::*;

`include "first_fit_block_allocator_assert.svh"

   // Widths follow from the zone geometry.
   localparam int DEPTH  = (ZONE_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int PW     = $clog2(ZONE_BYTES);       // positions inside the zone
   localparam int SW     = $clog2(ZONE_BYTES + 1);   // tag size / prev fields
   localparam int TW     = SW + 2;                   // merged totals before clamp
   localparam int AW     = (TW > REQ_ROUND_W) ? TW : REQ_ROUND_W;

   typedef struct packed {
      logic          free;
      logic [SW-1:0] prev;
      logic [SW-1:0] size;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   // Sequencer codes.
   localparam logic [4:0] S_INIT     = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] A_PREP     = 5'd2;
   localparam logic [4:0] A_RD       = 5'd3;
   localparam logic [4:0] A_CHK      = 5'd4;
   localparam logic [4:0] A_SPLIT0   = 5'd5;
   localparam logic [4:0] A_SPLIT1   = 5'd6;
   localparam logic [4:0] A_AFT_RD   = 5'd7;
   localparam logic [4:0] A_AFT_WR   = 5'd8;
   localparam logic [4:0] A_BLK_RD   = 5'd9;
   localparam logic [4:0] A_BLK_WR   = 5'd10;
   localparam logic [4:0] F_CHK      = 5'd11;
   localparam logic [4:0] F_RD       = 5'd12;
   localparam logic [4:0] F_MARK     = 5'd13;
   localparam logic [4:0] F_NXT_RD   = 5'd14;
   localparam logic [4:0] F_NXT_CHK  = 5'd15;
   localparam logic [4:0] F_PRV      = 5'd16;
   localparam logic [4:0] F_PRV_RD   = 5'd17;
   localparam logic [4:0] F_PRV_CHK  = 5'd18;
   localparam logic [4:0] F_HEAD_RD  = 5'd19;
   localparam logic [4:0] F_HEAD_WR  = 5'd20;
   localparam logic [4:0] F_TAIL_RD  = 5'd21;
   localparam logic [4:0] F_TAIL_WR  = 5'd22;
   localparam logic [4:0] S_RESP     = 5'd23;

   localparam logic [SW-1:0] INIT_SIZE = SW'(ZONE_BYTES - HEADER_BYTES);
   localparam logic [TW-1:0] ZONE_T    = TW'(ZONE_BYTES);

   function automatic logic [SLOT_W-1:0] slot_of(input logic [PW-1:0] p);
      slot_of = SLOT_W'(p / ALIGN_BYTES);
   endfunction

   // Registers.
   logic [4:0]             state_ff,    state_in;
   logic [PW-1:0]          pos_ff,      pos_in;
   logic [PW-1:0]          aux_ff,      aux_in;
   logic [PW-1:0]          head_ff,     head_in;
   tag_type                tag_ff,      tag_in;
   logic [TW-1:0]          total_ff,    total_in;
   logic [SW-1:0]          rest_ff,     rest_in;
   logic [REQ_ROUND_W-1:0] size_ff,     size_in;
   logic [REQ_ROUND_W-1:0] size_hi_ff,  size_hi_in;
   logic [OFF_W-1:0]       boff_ff,     boff_in;
   logic                   split_ff,    split_in;
   logic                   aft_ok_ff,   aft_ok_in;
   logic [OFF_W-1:0]       res_off_ff,  res_off_in;
   logic                   res_ok_ff,   res_ok_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Tag RAM and shared adder hookup.
   logic                   wr_en;
   logic [PW-1:0]          wr_pos;
   tag_type                wr_tag;
   logic                   rd_en;
   logic [PW-1:0]          rd_pos;
   logic [TAG_W-1:0]       rd_raw;
   tag_type                rd_tag;
   logic [AW-1:0]          alu_a;
   logic [AW-1:0]          alu_b;
   alu_op_type             alu_op;
   logic [AW-1:0]          alu_res;
   alu_flags_type          alu_flags;
   logic [REQ_ROUND_W-1:0] req_up;
   logic                   req_take;
   logic                   rsp_load;

   assign rd_tag = tag_type'(rd_raw);

   ffba_ram #(
      .WIDTH (TAG_W),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_of(wr_pos)),
      .wr_data (wr_tag),
      .rd_en   (rd_en),
      .rd_addr (slot_of(rd_pos)),
      .rd_data (rd_raw)
   );

   ffba_alu #(
      .W            (AW),
      .HEADER_BYTES (HEADER_BYTES),
      .ZONE_BYTES   (ZONE_BYTES)
   ) u_alu (
      .opa   (alu_a),
      .opb   (alu_b),
      .op    (alu_op),
      .res   (alu_res),
      .flags (alu_flags)
   );

   // Round the request up to the alignment grain.
   assign req_up = REQ_ROUND_W'((32'(req_data.request_size) + 32'(ALIGN_BYTES - 1))
                                / ALIGN_BYTES * ALIGN_BYTES);

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // Read address: walk position, side pointer, or merge head.
   always_comb begin
      rd_en  = 1'b0;
      rd_pos = pos_ff;
      case (state_ff)
         A_RD, A_BLK_RD, F_RD: begin
            rd_en = 1'b1;
         end
         A_AFT_RD, F_NXT_RD, F_PRV_RD, F_TAIL_RD: begin
            rd_en  = 1'b1;
            rd_pos = aux_ff;
         end
         F_HEAD_RD: begin
            rd_en  = 1'b1;
            rd_pos = head_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Sequencer: one tag access and one adder pass per step.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      aux_in       = aux_ff;
      head_in      = head_ff;
      tag_in       = tag_ff;
      total_in     = total_ff;
      rest_in      = rest_ff;
      size_in      = size_ff;
      size_hi_in   = size_hi_ff;
      boff_in      = boff_ff;
      split_in     = split_ff;
      aft_ok_in    = aft_ok_ff;
      res_off_in   = res_off_ff;
      res_ok_in    = res_ok_ff;
      wr_en        = 1'b0;
      wr_pos       = pos_ff;
      wr_tag       = rd_tag;
      alu_a        = AW'(pos_ff);
      alu_b        = '0;
      alu_op       = '{sub: 1'b0, hdr: 1'b1};

      case (state_ff)
         S_INIT: begin
            // Seed the whole zone as one free block.
            wr_en    = 1'b1;
            wr_pos   = '0;
            wr_tag   = '{free: 1'b1, prev: '0, size: INIT_SIZE};
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (req_take) begin
               size_in    = req_up;
               boff_in    = req_data.block_offset;
               pos_in     = '0;
               res_off_in = '0;
               res_ok_in  = 1'b0;
               state_in   = (req_data.opcode == OP_ALLOC) ? A_PREP : F_CHK;
            end
         end

         A_PREP: begin
            // Split threshold: request + header + alignment.
            alu_a      = AW'(size_ff);
            alu_b      = AW'(ALIGN_BYTES);
            size_hi_in = REQ_ROUND_W'(alu_res);
            state_in   = A_RD;
         end

         A_RD: begin
            state_in = A_CHK;
         end

         A_CHK: begin
            // End of this block = pos + header + size.
            alu_a = AW'(pos_ff);
            alu_b = AW'(rd_tag.size);
            if (rd_tag.size == '0 || alu_flags.gt_zone) begin
               state_in = S_RESP;  // broken chain
            end else if (rd_tag.free && (AW'(rd_tag.size) >= AW'(size_ff))) begin
               tag_in    = rd_tag;
               split_in  = AW'(rd_tag.size) > AW'(size_hi_ff);
               aft_ok_in = !alu_flags.ge_zone;
               aux_in    = PW'(alu_res);
               state_in  = (AW'(rd_tag.size) > AW'(size_hi_ff)) ? A_SPLIT0 : A_BLK_RD;
            end else if (alu_flags.ge_zone) begin
               state_in = S_RESP;  // walked off the zone end
            end else begin
               pos_in   = PW'(alu_res);
               state_in = A_RD;
            end
         end

         A_SPLIT0: begin
            // Remainder payload = size - request - header.
            alu_a    = AW'(tag_ff.size);
            alu_b    = AW'(size_ff);
            alu_op   = '{sub: 1'b1, hdr: 1'b1};
            rest_in  = SW'(alu_res);
            state_in = A_SPLIT1;
         end

         A_SPLIT1: begin
            // Write the new free remainder header.
            alu_a    = AW'(pos_ff);
            alu_b    = AW'(size_ff);
            wr_en    = 1'b1;
            wr_pos   = PW'(alu_res);
            wr_tag   = '{free: 1'b1, prev: SW'(size_ff), size: rest_ff};
            state_in = aft_ok_ff ? A_AFT_RD : A_BLK_RD;
         end

         A_AFT_RD: begin
            state_in = A_AFT_WR;
         end

         A_AFT_WR: begin
            wr_en    = 1'b1;
            wr_pos   = aux_ff;
            wr_tag   = '{free: rd_tag.free, prev: rest_ff, size: rd_tag.size};
            state_in = A_BLK_RD;
         end

         A_BLK_RD: begin
            state_in = A_BLK_WR;
         end

         A_BLK_WR: begin
            // Mark taken; shrink when split. Payload sits after the header.
            alu_a      = AW'(pos_ff);
            alu_b      = '0;
            wr_en      = 1'b1;
            wr_pos     = pos_ff;
            wr_tag     = '{free: 1'b0, prev: rd_tag.prev,
                           size: split_ff ? SW'(size_ff) : rd_tag.size};
            res_off_in = OFF_W'(alu_res);
            res_ok_in  = 1'b1;
            state_in   = S_RESP;
         end

         F_CHK: begin
            // Block start = offset - header; must be aligned and inside the zone.
            alu_a  = AW'(boff_ff);
            alu_b  = '0;
            alu_op = '{sub: 1'b1, hdr: 1'b1};
            if (!alu_flags.neg && ((alu_res % ALIGN_BYTES) == 0) && !alu_flags.ge_zone) begin
               pos_in   = PW'(alu_res);
               state_in = F_RD;
            end else begin
               state_in = S_RESP;
            end
         end

         F_RD: begin
            state_in = F_MARK;
         end

         F_MARK: begin
            alu_a    = AW'(pos_ff);
            alu_b    = AW'(rd_tag.size);
            wr_en    = 1'b1;
            wr_pos   = pos_ff;
            wr_tag   = '{free: 1'b1, prev: rd_tag.prev, size: rd_tag.size};
            tag_in   = '{free: 1'b1, prev: rd_tag.prev, size: rd_tag.size};
            total_in = TW'(rd_tag.size);
            if (!alu_flags.ge_zone) begin
               aux_in   = PW'(alu_res);
               state_in = F_NXT_RD;
            end else begin
               state_in = F_PRV;
            end
         end

         F_NXT_RD: begin
            state_in = F_NXT_CHK;
         end

         F_NXT_CHK: begin
            // Absorb a free successor.
            alu_a = AW'(total_ff);
            alu_b = AW'(rd_tag.size);
            if (rd_tag.free) begin
               total_in = TW'(alu_res);
            end
            state_in = F_PRV;
         end

         F_PRV: begin
            // Predecessor start = start - header - prev; skip if prev is zero, at zone start or before it.
            alu_a   = AW'(pos_ff);
            alu_b   = AW'(tag_ff.prev);
            alu_op  = '{sub: 1'b1, hdr: 1'b1};
            head_in = pos_ff;
            if (tag_ff.prev != '0 && pos_ff != '0 && !alu_flags.neg) begin
               aux_in   = PW'(alu_res);
               state_in = F_PRV_RD;
            end else begin
               state_in = F_HEAD_RD;
            end
         end

         F_PRV_RD: begin
            state_in = F_PRV_CHK;
         end

         F_PRV_CHK: begin
            alu_a = AW'(total_ff);
            alu_b = AW'(rd_tag.size);
            if (rd_tag.free) begin
               total_in = TW'(alu_res);
               head_in  = aux_ff;
            end
            state_in = F_HEAD_RD;
         end

         F_HEAD_RD: begin
            // Saturate the merged size at the zone size.
            if (total_ff > ZONE_T) begin
               total_in = ZONE_T;
            end
            state_in = F_HEAD_WR;
         end

         F_HEAD_WR: begin
            alu_a      = AW'(head_ff);
            alu_b      = AW'(total_ff);
            wr_en      = 1'b1;
            wr_pos     = head_ff;
            wr_tag     = '{free: 1'b1, prev: rd_tag.prev, size: SW'(total_ff)};
            res_ok_in  = 1'b1;
            if (!alu_flags.ge_zone) begin
               aux_in   = PW'(alu_res);
               state_in = F_TAIL_RD;
            end else begin
               state_in = S_RESP;
            end
         end

         F_TAIL_RD: begin
            state_in = F_TAIL_WR;
         end

         F_TAIL_WR: begin
            // Fix the follower's previous-size tag.
            wr_en    = 1'b1;
            wr_pos   = aux_ff;
            wr_tag   = '{free: rd_tag.free, prev: SW'(total_ff), size: rd_tag.size};
            state_in = S_RESP;
         end

         S_RESP: begin
            // Hold until the output register is free.
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop it once taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_data_in  = '{payload_offset: res_off_ff, ok: res_ok_ff};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      aux_ff      <= aux_in;
      head_ff     <= head_in;
      tag_ff      <= tag_in;
      total_ff    <= total_in;
      rest_ff     <= rest_in;
      size_ff     <= size_in;
      size_hi_ff  <= size_hi_in;
      boff_ff     <= boff_in;
      split_ff    <= split_in;
      aft_ok_ff   <= aft_ok_in;
      res_off_ff  <= res_off_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted request keeps the block busy for at least the next cycle.
   `FFBA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_ready)
   // The tag RAM is never written while waiting for a request.
   `FFBA_ASSERT_NOW(a_no_write_idle, clock, reset, state_ff == S_IDLE, !wr_en)
   // A result posted from the respond step is visible on the next cycle.
   `FFBA_ASSERT_NEXT(a_post_result, clock, reset, rsp_load, rsp_valid && req_ready)
   // The merged size written back never exceeds the zone.
   `FFBA_ASSERT_NOW(a_total_clamped, clock, reset, state_ff == F_HEAD_WR, total_ff <= ZONE_T)

endmodule
